// ===== src/bfsp_pkg.sv =====
// shared types and constants for the bellman-ford shortest path block
package bfsp_pkg;

	localparam int VCOUNT_W = 7;
	localparam int VID_W    = 6;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W   = 32;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 3;

	localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	localparam logic REG_VCOUNT = 1'b0;
	localparam logic REG_SOURCE = 1'b1;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_FETCH,
		S_EDGE,
		S_ADD,
		S_CMP,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_WAIT
	} bfsp_state_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [VID_W-1:0]           to_v;
		logic [VID_W-1:0]           from_v;
	} edge_t;

	typedef struct packed {
		logic add_en;
		logic edge_ok;
		logic reach_to;
	} relax_ctl_t;

endpackage

// ===== src/bfsp_relax.sv =====
// shared relaxation unit: saturating add stage and improvement compare
module bfsp_relax (
	input  logic                                clk,
	input  bfsp_pkg::relax_ctl_t                ctl,
	input  logic signed [bfsp_pkg::DIST_W-1:0]   dist_from,
	input  logic signed [bfsp_pkg::WEIGHT_W-1:0] weight,
	input  logic signed [bfsp_pkg::DIST_W-1:0]   dist_to,
	output logic signed [bfsp_pkg::DIST_W-1:0]   cand,
	output logic                                improve
);
	import bfsp_pkg::*;

	logic signed [DIST_W:0]   sum;
	logic signed [DIST_W-1:0] sat;
	logic signed [DIST_W-1:0] cand_q;

	assign sum = {dist_from[DIST_W-1], dist_from}
		+ {{(DIST_W + 1 - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};

	always_comb begin
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			sat = sum[DIST_W] ? DIST_MIN : DIST_MAX;
		end else begin
			sat = sum[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_en) begin
			cand_q <= sat;
		end
	end

	assign cand    = cand_q;
	assign improve = ctl.edge_ok && (!ctl.reach_to || (cand_q < dist_to));

endmodule

// ===== src/bellman_ford_shortest_path.sv =====
// top level: edge store, distance store, run sequencer and ports
//
// Usage:
//  - s_* channel takes items: s_tuser is the operation, s_tdata the edge.
//    A load (operation 0) gives no result; an edge past the store capacity
//    or with an endpoint at or beyond the effective vertex count is dropped
//    and remembered. A run (operation 1) solves from source_vertex.
//  - m_* channel gives the results of a run: one per vertex in vertex order
//    with tlast on the final one, or a single negative-cycle result.
//  - Registers vertex_count (0x0) and source_vertex (0x4) sit on the APB
//    port. Write them only while the block is idle; the block does not check.
//  - A run has a setup state, then fetch, edge, add and compare states per
//    stored edge per pass over (effective vertex count + 1) passes, the last
//    a check pass, then read, load and wait states per result. s_tready is low
//    for the whole run.
//  - If the receiver stalls, the current result holds on m_* and the
//    sequencer waits. After the last result the edge store and drop flag
//    are empty again.
//  - Reset empties the edge store, clears the drop flag, and sets
//    vertex_count to 64 and source_vertex to 0.
module bellman_ford_shortest_path #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bfsp_pkg::PADDR_W-1:0]      paddr,
	input  logic [bfsp_pkg::PDATA_W-1:0]      pwdata,
	output logic [bfsp_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// edge_from [5:0], edge_to [11:6], edge_weight [27:12], zero [31:28]
	input  logic [bfsp_pkg::S_DATA_W-1:0]     s_tdata,
	// operation [0]
	input  logic                              s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// vertex_id [5:0], distance [37:6], zero [39:38]
	output logic [bfsp_pkg::M_DATA_W-1:0]     m_tdata,
	// unreachable [0], negative_cycle [1], edge_dropped [2]
	output logic [bfsp_pkg::M_USER_W-1:0]     m_tuser,
	output logic                              m_tlast
);
	import bfsp_pkg::*;

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int FW = $clog2(MAX_EDGES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	bfsp_state_t state_q, state_d;

	logic [VCOUNT_W-1:0] vcount_q;
	logic [VID_W-1:0]    source_q;
	logic [VCOUNT_W-1:0] nv;

	logic [FW-1:0]           fill_q;
	logic                    drop_q;
	logic [FW-1:0]           edge_idx_q;
	logic [VCOUNT_W-1:0]     round_q;
	logic                    check_q;
	logic                    neg_q;
	logic [VCOUNT_W-1:0]     vtx_q;
	logic [MAX_VERTICES-1:0] reach_q;

	edge_t edge_mem [MAX_EDGES];
	edge_t edge_q;
	edge_t in_edge;

	logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
	logic [DIST_W-1:0] rda_q;
	logic [DIST_W-1:0] rdb_q;

	logic              ok_q;
	logic              reach_to_q;
	relax_ctl_t        relax_ctl;
	logic signed [DIST_W-1:0] cand;
	logic              improve;

	logic              s_fire;
	logic              cfg_wr;
	logic              edge_in_range;
	logic              edge_last;
	logic              round_last;
	logic              src_ok;
	logic              vtx_last;

	logic              dw_en;
	logic [VW-1:0]     dw_addr;
	logic [DIST_W-1:0] dw_data;
	logic [VW-1:0]     rda_addr;

	logic [VID_W-1:0]  out_id_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_unr_q;
	logic              out_neg_q;
	logic              out_drop_q;
	logic              out_last_q;

	// effective vertex count
	always_comb begin
		if (vcount_q == '0) begin
			nv = VCOUNT_W'(1);
		end else if (vcount_q > VCOUNT_W'(MAX_VERTICES)) begin
			nv = VCOUNT_W'(MAX_VERTICES);
		end else begin
			nv = vcount_q;
		end
	end

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_VCOUNT: prdata = PDATA_W'(vcount_q);
			REG_SOURCE: prdata = PDATA_W'(source_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
			source_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_VCOUNT: vcount_q <= pwdata[VCOUNT_W-1:0];
				REG_SOURCE: source_q <= pwdata[VID_W-1:0];
				default: ;
			endcase
		end
	end

	// input decode
	assign in_edge.from_v = s_tdata[VID_W-1:0];
	assign in_edge.to_v   = s_tdata[2*VID_W-1:VID_W];
	assign in_edge.weight = s_tdata[2*VID_W+WEIGHT_W-1:2*VID_W];
	assign s_fire = s_tvalid && s_tready;
	assign edge_in_range = ({1'b0, in_edge.from_v} < nv) && ({1'b0, in_edge.to_v} < nv);

	assign edge_last  = (edge_idx_q + FW'(1)) == fill_q;
	assign round_last = (round_q + VCOUNT_W'(1)) == nv;
	assign src_ok     = {1'b0, source_q} < nv;
	assign vtx_last   = (vtx_q + VCOUNT_W'(1)) == nv;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire && s_tuser == OP_RUN) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				state_d = (fill_q == '0) ? S_OUT_RD : S_FETCH;
			end
			S_FETCH: state_d = S_EDGE;
			S_EDGE:  state_d = S_ADD;
			S_ADD:   state_d = S_CMP;
			S_CMP: begin
				if (check_q && improve) begin
					state_d = S_OUT_LD;
				end else if (edge_last && check_q) begin
					state_d = S_OUT_RD;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_OUT_RD: state_d = S_OUT_LD;
			S_OUT_LD: state_d = S_OUT_WAIT;
			S_OUT_WAIT: begin
				if (m_tready) begin
					state_d = out_last_q ? S_IDLE : S_OUT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready          = 1'b0;
		m_tvalid          = 1'b0;
		dw_en             = 1'b0;
		dw_addr           = edge_q.to_v[VW-1:0];
		dw_data           = cand;
		rda_addr          = edge_q.from_v[VW-1:0];
		relax_ctl.add_en  = 1'b0;
		relax_ctl.edge_ok = ok_q;
		relax_ctl.reach_to = reach_to_q;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_INIT: begin
				dw_en   = src_ok;
				dw_addr = source_q[VW-1:0];
				dw_data = '0;
			end
			S_ADD:  relax_ctl.add_en = 1'b1;
			S_CMP:  dw_en = improve && !check_q;
			S_OUT_RD: rda_addr = vtx_q[VW-1:0];
			S_OUT_WAIT: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_fire && s_tuser == OP_LOAD && edge_in_range
				&& fill_q < FW'(MAX_EDGES)) begin
			edge_mem[fill_q[AW-1:0]] <= in_edge;
		end
		if (state_q == S_FETCH) begin
			edge_q <= edge_mem[edge_idx_q[AW-1:0]];
		end
	end

	// distance store
	always_ff @(posedge clk) begin
		if (dw_en) begin
			dist_mem[dw_addr] <= dw_data;
		end
		rda_q <= dist_mem[rda_addr];
		rdb_q <= dist_mem[edge_q.to_v[VW-1:0]];
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			drop_q     <= 1'b0;
			edge_idx_q <= '0;
			round_q    <= '0;
			check_q    <= 1'b0;
			neg_q      <= 1'b0;
			vtx_q      <= '0;
			reach_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_fire && s_tuser == OP_LOAD) begin
						if (edge_in_range && fill_q < FW'(MAX_EDGES)) begin
							fill_q <= fill_q + FW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				S_INIT: begin
					for (int i = 0; i < MAX_VERTICES; i++) begin
						reach_q[i] <= src_ok && (source_q[VW-1:0] == VW'(i));
					end
					edge_idx_q <= '0;
					round_q    <= '0;
					check_q    <= 1'b0;
					neg_q      <= 1'b0;
					vtx_q      <= '0;
				end
				S_CMP: begin
					if (check_q && improve) begin
						neg_q <= 1'b1;
					end else begin
						if (improve) begin
							reach_q[edge_q.to_v[VW-1:0]] <= 1'b1;
						end
						if (edge_last) begin
							edge_idx_q <= '0;
							if (round_last) begin
								check_q <= 1'b1;
							end else begin
								round_q <= round_q + VCOUNT_W'(1);
							end
						end else begin
							edge_idx_q <= edge_idx_q + FW'(1);
						end
					end
				end
				S_OUT_WAIT: begin
					if (m_tready) begin
						if (out_last_q) begin
							fill_q <= '0;
							drop_q <= 1'b0;
						end else begin
							vtx_q <= vtx_q + VCOUNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// per-edge operand capture
	always_ff @(posedge clk) begin
		if (state_q == S_EDGE) begin
			ok_q <= ({1'b0, edge_q.from_v} < nv) && ({1'b0, edge_q.to_v} < nv)
				&& reach_q[edge_q.from_v[VW-1:0]];
			reach_to_q <= reach_q[edge_q.to_v[VW-1:0]];
		end
	end

	bfsp_relax u_relax (
		.clk       (clk),
		.ctl       (relax_ctl),
		.dist_from (rda_q),
		.weight    (edge_q.weight),
		.dist_to   (rdb_q),
		.cand      (cand),
		.improve   (improve)
	);

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT_LD) begin
			out_drop_q <= drop_q;
			if (neg_q) begin
				out_id_q   <= '0;
				out_dist_q <= '0;
				out_unr_q  <= 1'b0;
				out_neg_q  <= 1'b1;
				out_last_q <= 1'b1;
			end else begin
				out_id_q   <= vtx_q[VID_W-1:0];
				out_dist_q <= reach_q[vtx_q[VW-1:0]] ? rda_q : DIST_MAX;
				out_unr_q  <= !reach_q[vtx_q[VW-1:0]];
				out_neg_q  <= 1'b0;
				out_last_q <= vtx_last;
			end
		end
	end

	assign m_tdata = {(M_DATA_W - DIST_W - VID_W)'(0), out_dist_q, out_id_q};
	assign m_tuser = {out_drop_q, out_neg_q, out_unr_q};
	assign m_tlast = out_last_q;

endmodule

// ===== tb/tb_bellman_ford_shortest_path.sv =====
`timescale 1ns / 1ps
// testbench for the bellman-ford shortest path block: distance predictor, stream and apb drivers

class path_scoreboard;
	typedef struct {
		logic [bfsp_pkg::VID_W-1:0]  vertex_id;
		logic [bfsp_pkg::DIST_W-1:0] distance;
		logic                        unreachable;
		logic                        negative_cycle;
		logic                        edge_dropped;
		logic                        last;
	} path_result_t;

	bfsp_pkg::edge_t edge_list[$];
	path_result_t    pending[$];
	bit              drop_seen;
	logic [6:0]      vertex_count;
	logic [5:0]      source_vertex;
	longint          dist_est[64];
	bit              reach[64];
	int              max_edges;
	int              max_vertices;
	int              errors;

	function new(int edges_cap, int vertices_cap);
		max_edges = edges_cap;
		max_vertices = vertices_cap;
		vertex_count = bfsp_pkg::VCOUNT_RESET;
		source_vertex = '0;
		drop_seen = 1'b0;
		errors = 0;
	endfunction

	function void note_register(logic idx, logic [31:0] value);
		if (idx == bfsp_pkg::REG_VCOUNT)
			vertex_count = value[6:0];
		else
			source_vertex = value[5:0];
	endfunction

	function bit relax_edge(bfsp_pkg::edge_t e, int nv, bit apply);
		longint cand;
		if (e.from_v >= nv || e.to_v >= nv || !reach[e.from_v])
			return 1'b0;
		cand = dist_est[e.from_v] + longint'($signed(e.weight));
		if (cand > longint'(bfsp_pkg::DIST_MAX))
			cand = longint'(bfsp_pkg::DIST_MAX);
		if (cand < longint'(bfsp_pkg::DIST_MIN))
			cand = longint'(bfsp_pkg::DIST_MIN);
		if (reach[e.to_v] && cand >= dist_est[e.to_v])
			return 1'b0;
		if (apply) begin
			dist_est[e.to_v] = cand;
			reach[e.to_v] = 1'b1;
		end
		return 1'b1;
	endfunction

	function void note_input(logic op, bfsp_pkg::edge_t e);
		int nv;
		bit neg;
		path_result_t res;
		if (vertex_count == 0)
			nv = 1;
		else if (vertex_count > max_vertices)
			nv = max_vertices;
		else
			nv = vertex_count;
		if (op == bfsp_pkg::OP_LOAD) begin
			if (edge_list.size() >= max_edges || e.from_v >= nv || e.to_v >= nv)
				drop_seen = 1'b1;
			else
				edge_list.push_back(e);
			return;
		end
		for (int i = 0; i < max_vertices; i++) begin
			dist_est[i] = 0;
			reach[i] = 1'b0;
		end
		if (source_vertex < nv)
			reach[source_vertex] = 1'b1;
		for (int r = 0; r < nv; r++)
			foreach (edge_list[j])
				void'(relax_edge(edge_list[j], nv, 1'b1));
		neg = 1'b0;
		foreach (edge_list[j])
			if (!neg)
				neg = relax_edge(edge_list[j], nv, 1'b0);
		if (neg) begin
			res.vertex_id = '0;
			res.distance = '0;
			res.unreachable = 1'b0;
			res.negative_cycle = 1'b1;
			res.edge_dropped = drop_seen;
			res.last = 1'b1;
			pending.push_back(res);
		end else begin
			for (int i = 0; i < nv; i++) begin
				res.vertex_id = 6'(i);
				res.distance = reach[i] ? 32'(dist_est[i]) : bfsp_pkg::DIST_MAX;
				res.unreachable = !reach[i];
				res.negative_cycle = 1'b0;
				res.edge_dropped = drop_seen;
				res.last = (i + 1 == nv);
				pending.push_back(res);
			end
		end
		edge_list.delete();
		drop_seen = 1'b0;
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endfunction

	function void check_result(logic [bfsp_pkg::M_DATA_W-1:0] data,
			logic [bfsp_pkg::M_USER_W-1:0] user, logic last);
		path_result_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: tdata %0h tuser %b tlast %b",
				$time, data, user, last);
			return;
		end
		want = pending.pop_front();
		compare_field("vertex_id", 32'(want.vertex_id), 32'(data[bfsp_pkg::VID_W-1:0]));
		compare_field("distance", want.distance,
			data[bfsp_pkg::VID_W+bfsp_pkg::DIST_W-1:bfsp_pkg::VID_W]);
		compare_field("unreachable", 32'(want.unreachable), 32'(user[0]));
		compare_field("negative_cycle", 32'(want.negative_cycle), 32'(user[1]));
		compare_field("edge_dropped", 32'(want.edge_dropped), 32'(user[2]));
		compare_field("last", 32'(want.last), 32'(last));
	endfunction
endclass

module tb_bellman_ford_shortest_path;
	import bfsp_pkg::*;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int IDLE_LIMIT   = 400000;
	localparam int ITEM_TARGET  = 460;
	localparam int LONG_HOLD    = 600;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic                m_tlast;

	path_scoreboard dist_board;
	int             items_sent;
	int             idle_cycles;
	bit             source_calm;
	bit             sink_calm;
	bit             long_hold_done;

	bellman_ford_shortest_path #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(logic op, logic [5:0] from_v, logic [5:0] to_v, logic [15:0] weight);
		int gap;
		edge_t e;
		gap = pick_gap(source_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		e.from_v = from_v;
		e.to_v = to_v;
		e.weight = weight;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= S_DATA_W'(e);
		do @(posedge clk); while (!s_tready);
		dist_board.note_input(op, e);
		items_sent++;
	endtask

	task automatic drain(int settle);
		s_tvalid <= 1'b0;
		while (dist_board.pending.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dist_board.note_register(idx, value);
	endtask

	task automatic config_regs(logic [6:0] vc, logic [5:0] src);
		write_reg(REG_VCOUNT, 32'(vc));
		write_reg(REG_SOURCE, 32'(src));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			dist_board.check_result(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		stall = 0;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!long_hold_done && m_tvalid && s_tvalid && !s_tready) begin
				// hold results back while the next transaction waits at the input
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap(sink_calm);
			end
		end
	end

	initial begin : stimulus
		int nv;
		int groups;
		int n_edges;
		int phase;
		logic [6:0] vc;
		logic [5:0] src;
		logic [5:0] f;
		logic [5:0] t;
		logic [5:0] prev_to;
		logic [15:0] w;
		dist_board = new(MAX_EDGES, MAX_VERTICES);
		items_sent = 0;
		source_calm = 1'b0;
		sink_calm = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_LOAD;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store at reset values
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// weight extremes, endpoints out of range dropped
		config_regs(4, 0);
		send_item(OP_LOAD, 0, 1, 16'h7fff);
		send_item(OP_LOAD, 1, 2, 16'h8000);
		send_item(OP_LOAD, 2, 3, 16'd5);
		send_item(OP_LOAD, 0, 63, 16'd1);
		send_item(OP_LOAD, 63, 0, 16'd1);
		send_item(OP_RUN, 63, 63, 16'hffff);
		drain(10);

		// reachable negative cycle
		config_regs(3, 0);
		send_item(OP_LOAD, 0, 1, 16'd1);
		send_item(OP_LOAD, 1, 2, 16'hfffd);
		send_item(OP_LOAD, 2, 1, 16'd1);
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// source beyond the vertex count
		config_regs(5, 5);
		send_item(OP_LOAD, 0, 1, 16'd2);
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// zero vertex count, negative self loop
		config_regs(0, 0);
		send_item(OP_LOAD, 0, 0, 16'hffff);
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// stale edges after the vertex count shrinks
		config_regs(64, 10);
		send_item(OP_LOAD, 10, 63, 16'd5);
		send_item(OP_LOAD, 63, 0, 16'd1);
		send_item(OP_LOAD, 10, 0, 16'h8000);
		drain(10);
		write_reg(REG_VCOUNT, 32'd20);
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// vertex count above the maximum
		config_regs(127, 63);
		send_item(OP_LOAD, 63, 0, 16'hffff);
		send_item(OP_LOAD, 0, 63, 16'd2);
		send_item(OP_RUN, 0, 0, 0);
		drain(10);

		// full edge store with overflow at the largest vertex count
		source_calm = 1'b1;
		config_regs(64, 6'($urandom_range(0, 63)));
		repeat (MAX_EDGES + 4)
			send_item(OP_LOAD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				16'($urandom_range(0, 16'h7fff)));
		send_item(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		drain(10);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			source_calm = ($urandom_range(0, 4) == 0);
			sink_calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: vc = 7'd0;
				1: vc = 7'd127;
				2: vc = 7'd64;
				3: vc = 7'($urandom_range(0, 127));
				default: vc = 7'($urandom_range(1, 8));
			endcase
			nv = (vc == 0) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
			if ($urandom_range(0, 7) == 0)
				src = 6'($urandom_range(0, 63));
			else
				src = 6'($urandom_range(0, nv - 1));
			config_regs(vc, src);
			groups = (phase == 0) ? 2 : $urandom_range(1, 3);
			repeat (groups) begin
				n_edges = $urandom_range(0, 12);
				prev_to = src;
				repeat (n_edges) begin
					if ($urandom_range(0, 6) == 0) begin
						f = 6'($urandom);
						t = 6'($urandom);
						w = 16'($urandom);
					end else begin
						f = $urandom_range(0, 1) ? prev_to : 6'($urandom_range(0, nv - 1));
						t = 6'($urandom_range(0, nv - 1));
						case ($urandom_range(0, 3))
							0: w = 16'($urandom);
							1: w = 16'(0 - $urandom_range(1, 20));
							default: w = 16'($urandom_range(0, 100));
						endcase
						prev_to = t;
					end
					send_item(OP_LOAD, f, t, w);
				end
				send_item(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
			end
			drain(10);
			phase++;
		end

		drain(20);
		if (dist_board.errors == 0 && dist_board.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
